FILE: design/lcs_pkg.sv
// Shared types and constants of the link connection supervisor.
package lcs_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned RetryW = 4;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ByteW  = 8;

  // Link states
  localparam logic [1:0] ST_DISCONNECTED = 2'd0;
  localparam logic [1:0] ST_CONNECTING   = 2'd1;
  localparam logic [1:0] ST_CONNECTED    = 2'd2;

  // Request types
  localparam logic [2:0] REQ_TICK       = 3'd0;
  localparam logic [2:0] REQ_PACKET     = 3'd1;
  localparam logic [2:0] REQ_CONNECT    = 3'd2;
  localparam logic [2:0] REQ_DISCONNECT = 3'd3;
  localparam logic [2:0] REQ_UPDATE     = 3'd4;

  // Packet kinds
  localparam logic [1:0] PKT_INFO  = 2'd0;
  localparam logic [1:0] PKT_ALIVE = 2'd1;
  localparam logic [1:0] PKT_ACK   = 2'd2;
  localparam logic [1:0] PKT_OTHER = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_INFO_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_WATCHDOG     = 2'd2;

  typedef struct packed {
    logic [1:0]        link;
    logic              startup_pend;
    logic              info_armed;
    logic [TimerW-1:0] info_rem;
    logic [RetryW-1:0] retries;
    logic              wd_armed;
    logic [TimerW-1:0] wd_rem;
    logic [LenW-1:0]   strip_len;
  } lcs_state_t;

  typedef struct packed {
    logic [TimerW-1:0] info_timeout;
    logic [RetryW-1:0] retry_limit;
    logic [TimerW-1:0] wd_ticks;
  } lcs_cfg_t;

  // Declared MSB first so the packed word matches the output tdata layout
  typedef struct packed {
    logic            strip_resized;
    logic [LenW-1:0] pixel_count;
    logic            update_accepted;
    logic            send_info_request;
    logic [1:0]      previous_status;
    logic            state_changed;
    logic [1:0]      link_status;
  } lcs_result_t;

endpackage

FILE: design/lcs_step.sv
// Next-state and result logic for one supervisor event.
module lcs_step (
  input  lcs_pkg::lcs_state_t            cur_i,
  input  lcs_pkg::lcs_cfg_t              cfg_i,
  input  logic [2:0]                     req_type_i,
  input  logic [1:0]                     packet_kind_i,
  input  logic [lcs_pkg::ByteW-1:0]      payload_high_i,
  input  logic [lcs_pkg::ByteW-1:0]      payload_low_i,
  output lcs_pkg::lcs_state_t            nxt_o,
  output lcs_pkg::lcs_result_t           res_o
);

  logic                       send;
  logic                       info_exp;
  logic                       wd_exp;
  logic                       resized;
  logic                       accepted;
  logic [lcs_pkg::LenW-1:0]   pc;

  assign pc = {payload_high_i, payload_low_i};

  always_comb begin
    nxt_o              = cur_i;
    nxt_o.startup_pend = 1'b0;
    send               = cur_i.startup_pend;
    info_exp           = 1'b0;
    wd_exp             = 1'b0;
    resized            = 1'b0;
    accepted           = 1'b0;
    case (req_type_i)
      lcs_pkg::REQ_TICK: begin
        if (cur_i.info_armed) begin
          if (cur_i.info_rem[lcs_pkg::TimerW-1:1] == '0) begin
            nxt_o.info_rem   = '0;
            nxt_o.info_armed = 1'b0;
            info_exp         = 1'b1;
          end else begin
            nxt_o.info_rem = cur_i.info_rem - 1'b1;
          end
        end
        if (info_exp) begin
          if (cur_i.retries >= cfg_i.retry_limit) begin
            nxt_o.link = lcs_pkg::ST_DISCONNECTED;
          end else begin
            nxt_o.retries    = cur_i.retries + 1'b1;
            send             = 1'b1;
            nxt_o.info_armed = 1'b1;
            nxt_o.info_rem   = cfg_i.info_timeout;
          end
        end
        if (cur_i.wd_armed) begin
          if (cur_i.wd_rem[lcs_pkg::TimerW-1:1] == '0) begin
            nxt_o.wd_rem   = '0;
            nxt_o.wd_armed = 1'b0;
            wd_exp         = 1'b1;
          end else begin
            nxt_o.wd_rem = cur_i.wd_rem - 1'b1;
          end
        end
        if (wd_exp) begin
          nxt_o.link = lcs_pkg::ST_DISCONNECTED;
        end
      end
      lcs_pkg::REQ_PACKET: begin
        case (packet_kind_i)
          lcs_pkg::PKT_INFO: begin
            if (pc != cur_i.strip_len) begin
              nxt_o.strip_len = pc;
              resized         = 1'b1;
            end
            nxt_o.info_armed = 1'b0;
            if (cur_i.link != lcs_pkg::ST_CONNECTED) begin
              nxt_o.link     = lcs_pkg::ST_CONNECTED;
              nxt_o.wd_armed = 1'b1;
              nxt_o.wd_rem   = cfg_i.wd_ticks;
            end
          end
          lcs_pkg::PKT_ALIVE, lcs_pkg::PKT_ACK: begin
            nxt_o.wd_armed = 1'b1;
            nxt_o.wd_rem   = cfg_i.wd_ticks;
            if (cur_i.link == lcs_pkg::ST_DISCONNECTED) begin
              nxt_o.link       = lcs_pkg::ST_CONNECTING;
              nxt_o.retries    = '0;
              send             = 1'b1;
              nxt_o.info_armed = 1'b1;
              nxt_o.info_rem   = cfg_i.info_timeout;
            end
          end
          default: begin
          end
        endcase
      end
      lcs_pkg::REQ_CONNECT: begin
        if (cur_i.link == lcs_pkg::ST_DISCONNECTED) begin
          nxt_o.link       = lcs_pkg::ST_CONNECTING;
          nxt_o.retries    = '0;
          send             = 1'b1;
          nxt_o.info_armed = 1'b1;
          nxt_o.info_rem   = cfg_i.info_timeout;
        end
      end
      lcs_pkg::REQ_DISCONNECT: begin
        nxt_o.link = lcs_pkg::ST_DISCONNECTED;
      end
      lcs_pkg::REQ_UPDATE: begin
        accepted = (cur_i.link == lcs_pkg::ST_CONNECTED);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.link_status       = nxt_o.link;
    res_o.state_changed     = (nxt_o.link != cur_i.link);
    res_o.previous_status   = cur_i.link;
    res_o.send_info_request = send;
    res_o.update_accepted   = accepted;
    res_o.pixel_count       = nxt_o.strip_len;
    res_o.strip_resized     = resized;
  end

endmodule

FILE: design/link_connection_supervisor.sv
// Top level of the link connection supervisor: state, config and output register.
//
//  channel  | dir | handshake                       | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready   | tuser: request type, packet kind
//           |     |                                 | tdata: pixel count bytes
//  m_axis   | out | m_axis_tvalid / m_axis_tready   | tdata: one result per event
//  cfg      | in  | cfg_valid_i / cfg_ready_o       | cfg_index_i, cfg_data_i
//
// One event per cycle while the output is not stalled: its whole update is one
// combinational step from the state registers into the state and result registers.
// Reset leaves the link connecting with the info timer armed and the first
// result flagging an info request send.
// A stalled result holds in the output register; a new event is taken in the
// cycle that register drains or while it is empty.
module link_connection_supervisor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // payload_high[7:0], payload_low[15:8]
  input  logic [4:0]  s_axis_tuser,  // req_type[2:0], packet_kind[4:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // link_status[1:0], state_changed[2], previous_status[4:3],
  // send_info_request[5], update_accepted[6], pixel_count[22:7], strip_resized[23]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [lcs_pkg::TimerW-1:0] InfoTimeoutRst = 16'd1000;
  localparam logic [lcs_pkg::RetryW-1:0] RetryLimitRst  = 4'd3;
  localparam logic [lcs_pkg::TimerW-1:0] WatchdogRst    = 16'd5000;

  lcs_pkg::lcs_cfg_t    cfg_q;
  lcs_pkg::lcs_state_t  state_q;
  lcs_pkg::lcs_state_t  state_d;
  lcs_pkg::lcs_result_t res_d;
  lcs_pkg::lcs_result_t res_q;
  logic                 m_valid_q;
  logic                 in_xfer;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

  lcs_step u_step (
    .cur_i          (state_q),
    .cfg_i          (cfg_q),
    .req_type_i     (s_axis_tuser[2:0]),
    .packet_kind_i  (s_axis_tuser[4:3]),
    .payload_high_i (s_axis_tdata[7:0]),
    .payload_low_i  (s_axis_tdata[15:8]),
    .nxt_o          (state_d),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.info_timeout <= InfoTimeoutRst;
      cfg_q.retry_limit  <= RetryLimitRst;
      cfg_q.wd_ticks     <= WatchdogRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lcs_pkg::CFG_INFO_TIMEOUT: cfg_q.info_timeout <= cfg_data_i;
        lcs_pkg::CFG_RETRY_LIMIT:  cfg_q.retry_limit  <= cfg_data_i[lcs_pkg::RetryW-1:0];
        lcs_pkg::CFG_WATCHDOG:     cfg_q.wd_ticks     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.link         <= lcs_pkg::ST_CONNECTING;
      state_q.startup_pend <= 1'b1;
      state_q.info_armed   <= 1'b1;
      state_q.info_rem     <= InfoTimeoutRst;
      state_q.retries      <= '0;
      state_q.wd_armed     <= 1'b0;
      state_q.wd_rem       <= '0;
      state_q.strip_len    <= '0;
      m_valid_q            <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      if (s_axis_tready) begin
        m_valid_q <= s_axis_tvalid;
      end
    end
  end

  // Result payload: load on every accepted event
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: design/lcs_checker.sv
// Port-level checks for the link connection supervisor, bound to the top level.
module lcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output register");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2] == (m_axis_tdata[1:0] != m_axis_tdata[4:3]))
    else $error("state_changed disagrees with status fields");

  a_update_connected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[1:0] == lcs_pkg::ST_CONNECTED)
    else $error("update accepted while not connected");

  a_resize_connected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[1:0] == lcs_pkg::ST_CONNECTED)
    else $error("strip resized without connected status");

endmodule

bind link_connection_supervisor lcs_checker u_lcs_checker (.*);
